/* sv/smpd_pkg.sv */
// shared types and constants for the six-axis motion packet decoder
// no dependencies; imported by the axis unit, the top level and the testbench
`default_nettype none

package smpd_pkg;

  // datapath widths
  localparam int ACC_W    = 32;
  localparam int SAMPLE_W = 16;
  localparam int BTN_W    = 9;

  // packet lengths
  localparam int DISP_LEN = 15;
  localparam int KEY_LEN  = 3;

  // configuration register indexes
  localparam logic [1:0] REG_DELTA_MODE = 2'd0;
  localparam logic [1:0] REG_DISP_CODE  = 2'd1;
  localparam logic [1:0] REG_KEY_CODE   = 2'd2;

  // reset values of the configuration registers
  localparam logic [7:0] DISP_CODE_RST = 8'd68;
  localparam logic [7:0] KEY_CODE_RST  = 8'd75;

  // result kinds
  typedef enum logic [1:0] {
    KIND_TRANSLATION = 2'd0,
    KIND_ROTATION    = 2'd1,
    KIND_BUTTON      = 2'd2,
    KIND_BAD_LENGTH  = 2'd3
  } kind_t;

  // input operations
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

endpackage

`default_nettype wire

/* sv/six_axis_motion_packet_decoder.sv */
// byte and clear requests: one per cycle while idle; bytes are buffered in a
// MAX_PACKET deep memory with a registered read port, one read per cycle
// displacement packet: S_FIRST and S_DECODE, then each of the six axes in turn
// (one shared adder: two byte reads and one add), then S_EMIT_T and S_EMIT_R
// key packet: S_K1-S_K3, then up to 9 button bits scanned, one per unstalled cycle
// synchronous active-high reset clears counters, accumulators, buttons and config
`default_nettype none

module six_axis_motion_packet_decoder
  import smpd_pkg::*;
#(
  parameter int MAX_PACKET = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration write channel
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [7:0]              cfg_data,
  // input request channel
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    operation,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    end_of_packet,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   kind,
  output logic signed [ACC_W-1:0]      x_value,
  output logic signed [ACC_W-1:0]      y_value,
  output logic signed [ACC_W-1:0]      z_value,
  output logic [3:0]                   button_number,
  output logic                         button_pressed,
  output logic                         last
);

  localparam int PTR_W = $clog2(MAX_PACKET);
  localparam int CNT_W = $clog2(MAX_PACKET + 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_FIRST  = 13'b0000000000010,
    S_DECODE = 13'b0000000000100,
    S_AX_HI  = 13'b0000000001000,
    S_AX_LO  = 13'b0000000010000,
    S_AX_ADD = 13'b0000000100000,
    S_EMIT_T = 13'b0000001000000,
    S_EMIT_R = 13'b0000010000000,
    S_BAD    = 13'b0000100000000,
    S_K1     = 13'b0001000000000,
    S_K2     = 13'b0010000000000,
    S_K3     = 13'b0100000000000,
    S_SCAN   = 13'b1000000000000
  } state_t;

  state_t state;

  // configuration
  logic       delta_mode;
  logic [7:0] disp_code;
  logic [7:0] key_code;

  // packet buffer
  logic [7:0]       mem [MAX_PACKET];
  logic [7:0]       rd_data;
  logic [PTR_W-1:0] ptr;
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] pkt_len;
  logic             wr_en;

  // axis datapath
  logic signed [ACC_W-1:0] acc [6];
  logic [2:0]              axis_idx;
  logic [7:0]              hi_byte;
  logic signed [ACC_W-1:0] alu_result;

  // buttons
  logic [BTN_W-1:0] button_word;
  logic [BTN_W-1:0] new_word;
  logic [BTN_W-1:0] diff;
  logic [BTN_W-1:0] diff_rest;
  logic [4:0]       key_hi;
  logic [3:0]       bit_idx;

  logic in_accept;
  logic out_free;
  logic emit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign wr_en     = in_accept && (operation == OP_BYTE) &&
                     (byte_count < CNT_W'(MAX_PACKET));
  assign diff_rest = diff >> bit_idx;

  // a result is loaded into the output register this cycle
  assign emit = out_free &&
                ((state == S_EMIT_T) || (state == S_EMIT_R) || (state == S_BAD) ||
                 ((state == S_SCAN) && diff[bit_idx]));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delta_mode <= 1'b0;
      disp_code  <= DISP_CODE_RST;
      key_code   <= KEY_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DELTA_MODE: delta_mode <= cfg_data[0];
        REG_DISP_CODE:  disp_code  <= cfg_data;
        REG_KEY_CODE:   key_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[byte_count[PTR_W-1:0]] <= data_byte;
    end
    rd_data <= mem[ptr];
  end

  // shared saturating adder, or sample pass-through in delta mode
  smpd_axis_alu u_alu (
    .acc     (acc[axis_idx]),
    .sample  ({hi_byte, rd_data}),
    .replace (delta_mode),
    .result  (alu_result)
  );

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      byte_count  <= '0;
      button_word <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        acc[i] <= '0;
      end
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (operation == OP_CLEAR) begin
              for (int i = 0; i < 6; i++) begin
                acc[i] <= '0;
              end
            end else begin
              if (end_of_packet) begin
                pkt_len    <= wr_en ? byte_count + CNT_W'(1) : byte_count;
                byte_count <= '0;
                ptr        <= '0;
                state      <= S_FIRST;
              end else if (wr_en) begin
                byte_count <= byte_count + CNT_W'(1);
              end
            end
          end
        end
        // wait for byte 0 to come out of the memory
        S_FIRST: begin
          state <= S_DECODE;
        end
        // classify the packet by its first byte and length
        S_DECODE: begin
          if (rd_data == disp_code) begin
            if (pkt_len != CNT_W'(DISP_LEN)) begin
              state <= S_BAD;
            end else begin
              ptr      <= PTR_W'(3);
              axis_idx <= '0;
              state    <= S_AX_HI;
            end
          end else if (rd_data == key_code) begin
            if (pkt_len != CNT_W'(KEY_LEN)) begin
              state <= S_BAD;
            end else begin
              ptr   <= PTR_W'(1);
              state <= S_K1;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        // axis: read high byte, read low byte, add
        S_AX_HI: begin
          ptr   <= ptr + PTR_W'(1);
          state <= S_AX_LO;
        end
        S_AX_LO: begin
          hi_byte <= rd_data;
          ptr     <= ptr + PTR_W'(1);
          state   <= S_AX_ADD;
        end
        S_AX_ADD: begin
          acc[axis_idx] <= alu_result;
          if (axis_idx == 3'd5) begin
            state <= S_EMIT_T;
          end else begin
            axis_idx <= axis_idx + 3'd1;
            state    <= S_AX_HI;
          end
        end
        S_EMIT_T: begin
          if (out_free) begin
            kind           <= KIND_TRANSLATION;
            x_value        <= acc[0];
            y_value        <= acc[1];
            z_value        <= acc[2];
            button_number  <= '0;
            button_pressed <= 1'b0;
            last           <= 1'b0;
            state          <= S_EMIT_R;
          end
        end
        S_EMIT_R: begin
          if (out_free) begin
            kind           <= KIND_ROTATION;
            x_value        <= acc[3];
            y_value        <= acc[4];
            z_value        <= acc[5];
            button_number  <= '0;
            button_pressed <= 1'b0;
            last           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_BAD: begin
          if (out_free) begin
            kind           <= KIND_BAD_LENGTH;
            x_value        <= '0;
            y_value        <= '0;
            z_value        <= '0;
            button_number  <= '0;
            button_pressed <= 1'b0;
            last           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        // key packet: fetch bytes 1 and 2, form the new button word
        S_K1: begin
          ptr   <= ptr + PTR_W'(1);
          state <= S_K2;
        end
        S_K2: begin
          key_hi <= rd_data[4:0];
          state  <= S_K3;
        end
        S_K3: begin
          new_word    <= {key_hi, rd_data[3:0]};
          diff        <= button_word ^ {key_hi, rd_data[3:0]};
          button_word <= {key_hi, rd_data[3:0]};
          bit_idx     <= '0;
          state       <= ((button_word ^ {key_hi, rd_data[3:0]}) == '0) ? S_IDLE : S_SCAN;
        end
        // walk the changed bits in ascending order
        S_SCAN: begin
          if (diff[bit_idx]) begin
            if (out_free) begin
              kind           <= KIND_BUTTON;
              x_value        <= '0;
              y_value        <= '0;
              z_value        <= '0;
              button_number  <= bit_idx + 4'd1;
              button_pressed <= new_word[bit_idx];
              last           <= (diff_rest[BTN_W-1:1] == '0);
              if (diff_rest[BTN_W-1:1] == '0) begin
                state <= S_IDLE;
              end else begin
                bit_idx <= bit_idx + 4'd1;
              end
            end
          end else begin
            bit_idx <= bit_idx + 4'd1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/smpd_axis_alu.sv */
// shared axis unit: replaces or saturating-adds one 16-bit sample into an accumulator
// depends on smpd_pkg for the datapath widths
`default_nettype none

module smpd_axis_alu
  import smpd_pkg::*;
(
  input  wire logic signed [ACC_W-1:0]    acc,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       replace,
  output logic signed [ACC_W-1:0]         result
);

  logic signed [ACC_W:0] sum;
  logic signed [ACC_W-1:0] sample_ext;

  // sign-extend the sample and form a one-bit-wider sum
  assign sample_ext = ACC_W'(sample);
  assign sum = {acc[ACC_W-1], acc} + {sample_ext[ACC_W-1], sample_ext};

  // clamp on overflow, or pass the sample in delta mode
  always_comb begin
    if (replace) begin
      result = sample_ext;
    end else if (sum[ACC_W] != sum[ACC_W-1]) begin
      result = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      result = sum[ACC_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* tb/smpd_result_checker.sv */
// result checker for the six-axis motion packet decoder: tracks config writes, predicts the
// results of every accepted request and compares them field by field with the result channel
// depends on smpd_pkg for result kinds, operations and register indexes
`default_nettype none

module smpd_result_checker
  import smpd_pkg::*;
#(
  parameter int MAX_PACKET = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic              operation,
  input  wire logic [7:0]        data_byte,
  input  wire logic              end_of_packet,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [1:0]        kind,
  input  wire logic signed [31:0] x_value,
  input  wire logic signed [31:0] y_value,
  input  wire logic signed [31:0] z_value,
  input  wire logic [3:0]        button_number,
  input  wire logic              button_pressed,
  input  wire logic              last,
  output int                     outstanding,
  output int                     mismatches
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t              kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [3:0]         bnum;
    logic               bpress;
    logic               last;
  } motion_result_t;

  motion_result_t     expected_q [$];

  // mirrored decoder state and configuration
  logic [7:0]         pkt_mem [MAX_PACKET];
  int unsigned        fill;
  logic signed [31:0] trans_acc [3];
  logic signed [31:0] rot_acc [3];
  logic [8:0]         buttons;
  logic               delta_mode;
  logic [7:0]         disp_code;
  logic [7:0]         key_code;

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  // big-endian signed 16-bit sample at a byte offset of the packet
  function automatic logic signed [31:0] axis_sample(int pos);
    logic [15:0] w;
    w = {pkt_mem[pos], pkt_mem[pos + 1]};
    return {{16{w[15]}}, w};
  endfunction

  // 32-bit signed add with saturation
  function automatic logic signed [31:0] sat_sum(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] s;
    s = $signed({a[31], a}) + $signed({b[31], b});
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

  task automatic push_result(kind_t k, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic [3:0] bnum, logic bpress);
    motion_result_t r;
    r.kind   = k;
    r.x      = x;
    r.y      = y;
    r.z      = z;
    r.bnum   = bnum;
    r.bpress = bpress;
    r.last   = 1'b0;
    expected_q.push_back(r);
  endtask

  // work out the results caused by one accepted request
  task automatic predict_request(logic op, logic [7:0] b, logic eop);
    int unsigned len;
    int          before_n;
    logic [8:0]  new_word;
    logic [8:0]  diff;
    if (op == OP_CLEAR) begin
      for (int i = 0; i < 3; i++) begin
        trans_acc[i] = '0;
        rot_acc[i]   = '0;
      end
      return;
    end
    if (fill < MAX_PACKET) begin
      pkt_mem[fill] = b;
      fill++;
    end
    if (!eop) return;
    len      = fill;
    fill     = 0;
    before_n = expected_q.size();
    if (pkt_mem[0] == disp_code) begin
      if (len != DISP_LEN) begin
        push_result(KIND_BAD_LENGTH, '0, '0, '0, '0, 1'b0);
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (delta_mode) begin
            trans_acc[i] = axis_sample(3 + 2 * i);
            rot_acc[i]   = axis_sample(9 + 2 * i);
          end else begin
            trans_acc[i] = sat_sum(trans_acc[i], axis_sample(3 + 2 * i));
            rot_acc[i]   = sat_sum(rot_acc[i], axis_sample(9 + 2 * i));
          end
        end
        push_result(KIND_TRANSLATION, trans_acc[0], trans_acc[1], trans_acc[2], '0, 1'b0);
        push_result(KIND_ROTATION, rot_acc[0], rot_acc[1], rot_acc[2], '0, 1'b0);
      end
    end else if (pkt_mem[0] == key_code) begin
      if (len != KEY_LEN) begin
        push_result(KIND_BAD_LENGTH, '0, '0, '0, '0, 1'b0);
      end else begin
        new_word = {pkt_mem[1][4:0], pkt_mem[2][3:0]};
        diff     = buttons ^ new_word;
        for (int i = 0; i < BTN_W; i++) begin
          if (diff[i]) push_result(KIND_BUTTON, '0, '0, '0, 4'(i + 1), new_word[i]);
        end
        buttons = new_word;
      end
    end
    if (expected_q.size() > before_n) expected_q[expected_q.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // watch the three channels
  always @(posedge clk) begin
    motion_result_t exp_r;
    if (rst) begin
      expected_q.delete();
      fill       = 0;
      buttons    = '0;
      delta_mode = 1'b0;
      disp_code  = DISP_CODE_RST;
      key_code   = KEY_CODE_RST;
      for (int i = 0; i < 3; i++) begin
        trans_acc[i] = '0;
        rot_acc[i]   = '0;
      end
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DELTA_MODE: delta_mode = cfg_data[0];
          REG_DISP_CODE:  disp_code  = cfg_data;
          REG_KEY_CODE:   key_code   = cfg_data;
          default: ;
        endcase
      end
      // compare a delivered result with the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no expectation: kind %0d", kind);
          mismatches++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("kind", exp_r.kind, kind);
          check_field("x_value", exp_r.x, x_value);
          check_field("y_value", exp_r.y, y_value);
          check_field("z_value", exp_r.z, z_value);
          check_field("button_number", exp_r.bnum, button_number);
          check_field("button_pressed", exp_r.bpress, button_pressed);
          check_field("last", exp_r.last, last);
        end
      end
      // accepted request
      if (in_valid && in_ready) predict_request(operation, data_byte, end_of_packet);
    end
    outstanding <= expected_q.size();
  end

endmodule

`default_nettype wire

/* tb/tb_six_axis_motion_packet_decoder.sv */
// top of the six-axis motion packet decoder testbench: clock, reset, request stimulus,
// config phases and verdict; depends on smpd_pkg, the decoder and smpd_result_checker
`default_nettype none

module tb_six_axis_motion_packet_decoder;
  import smpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PACKET    = 16;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 40;
  localparam int SEGMENT_ITEMS = 56;

  typedef logic [7:0] byte_q_t [$];

  logic               clk;
  logic               rst           = 1'b1;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index     = REG_DELTA_MODE;
  logic [7:0]         cfg_data      = 8'd0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic               operation     = OP_BYTE;
  logic [7:0]         data_byte     = 8'd0;
  logic               end_of_packet = 1'b0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [1:0]         kind;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [31:0] z_value;
  logic [3:0]         button_number;
  logic               button_pressed;
  logic               last;

  int                 outstanding;
  int                 mismatches;
  int                 in_idle_pct   = 19;
  int                 out_idle_pct  = 45;
  int                 items_sent    = 0;
  int                 cycles        = 0;
  logic [7:0]         cur_disp      = DISP_CODE_RST;
  logic [7:0]         cur_key       = KEY_CODE_RST;
  logic [7:0]         prev_b1       = 8'd0;
  logic [7:0]         prev_b2       = 8'd0;

  six_axis_motion_packet_decoder #(.MAX_PACKET(MAX_PACKET)) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .data_byte(data_byte),
    .end_of_packet(end_of_packet),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .x_value(x_value), .y_value(y_value), .z_value(z_value),
    .button_number(button_number), .button_pressed(button_pressed), .last(last)
  );

  smpd_result_checker #(.MAX_PACKET(MAX_PACKET)) checker_i (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .data_byte(data_byte),
    .end_of_packet(end_of_packet),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .x_value(x_value), .y_value(y_value), .z_value(z_value),
    .button_number(button_number), .button_pressed(button_pressed), .last(last),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** six_axis_motion_packet_decoder: FAILED **");
    $finish;
  end

  // result receiver with random back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // one request, with random idle cycles ahead of it
  task automatic send_item(logic op, logic [7:0] b, logic eop);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    data_byte     <= b;
    end_of_packet <= eop;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // bytes of one packet, optionally with clear requests mixed in
  task automatic send_packet(byte_q_t bytes, bit mix_clear);
    foreach (bytes[i]) begin
      if (mix_clear && $urandom_range(99) < 3) begin
        send_item(OP_CLEAR, 8'($urandom), 1'($urandom_range(1)));
      end
      send_item(OP_BYTE, bytes[i], i == bytes.size() - 1);
    end
  endtask

  // wait until every result is in and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers back to back
  task automatic configure(logic delta, logic [7:0] dcode, logic [7:0] kcode);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    idx = '{REG_DELTA_MODE, REG_DISP_CODE, REG_KEY_CODE};
    val = '{{7'd0, delta}, dcode, kcode};
    cfg_valid <= 1'b1;
    for (int r = 0; r < 3; r++) begin
      cfg_index <= idx[r];
      cfg_data  <= val[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_disp = dcode;
    cur_key  = kcode;
  endtask

  // mostly well-formed packets with random content, plus noise
  task automatic random_traffic(int n_items);
    int       start;
    int       pick;
    int       len;
    byte_q_t  pkt;
    logic [7:0] b;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      pkt.delete();
      if (pick < 28) begin
        // displacement packet
        pkt.push_back(cur_disp);
        repeat (DISP_LEN - 1) pkt.push_back(8'($urandom));
        send_packet(pkt, 1'b1);
      end else if (pick < 63) begin
        // key packet, sometimes with no button change
        if ($urandom_range(99) >= 25) begin
          prev_b1 = 8'($urandom);
          prev_b2 = 8'($urandom);
        end
        pkt = '{cur_key, prev_b1, prev_b2};
        send_packet(pkt, 1'b1);
      end else if (pick < 75) begin
        // known code with the wrong length, overlong ones included
        b   = $urandom_range(1) ? cur_disp : cur_key;
        len = $urandom_range(1, 20);
        if (b == cur_disp && len == DISP_LEN) len++;
        if (b != cur_disp && len == KEY_LEN) len++;
        pkt.push_back(b);
        repeat (len - 1) pkt.push_back(8'($urandom));
        send_packet(pkt, 1'b1);
      end else if (pick < 88) begin
        // unknown first byte
        do b = 8'($urandom); while (b == cur_disp || b == cur_key);
        pkt.push_back(b);
        repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
        send_packet(pkt, 1'b1);
      end else begin
        send_item(OP_CLEAR, 8'($urandom), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    byte_q_t    pkt;
    logic [7:0] same_code;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: all buttons pressed, extreme axes, clear, short and unknown packets, release
    pkt = '{KEY_CODE_RST, 8'hFF, 8'hFF};
    send_packet(pkt, 1'b0);
    pkt = '{DISP_CODE_RST, 8'h00, 8'hFF, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h01,
            8'hFF, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF};
    send_packet(pkt, 1'b0);
    send_item(OP_CLEAR, 8'hAA, 1'b1);
    send_item(OP_BYTE, DISP_CODE_RST, 1'b1);
    send_item(OP_BYTE, 8'h00, 1'b1);
    pkt = '{KEY_CODE_RST, 8'h00, 8'h00};
    send_packet(pkt, 1'b0);

    // accumulate mode, default codes
    settle();
    configure(1'b0, DISP_CODE_RST, KEY_CODE_RST);
    random_traffic(SEGMENT_ITEMS);

    // delta mode, extreme codes, idling swapped
    settle();
    in_idle_pct  = 45;
    out_idle_pct = 19;
    configure(1'b1, 8'h00, 8'hFF);
    random_traffic(SEGMENT_ITEMS);

    // accumulate mode, codes the other way round, no idling
    settle();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    configure(1'b0, 8'hFF, 8'h00);
    random_traffic(SEGMENT_ITEMS);

    // equal codes: displacement meaning takes precedence
    settle();
    same_code = 8'($urandom_range(1, 254));
    configure(1'b1, same_code, same_code);
    random_traffic(SEGMENT_ITEMS);

    settle();
    if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** six_axis_motion_packet_decoder: PASSED **");
    end else begin
      $display("** six_axis_motion_packet_decoder: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
